### rtl/tspu_pkg.sv
// ----------------------------------------------------------------------------
// tspu_pkg
// Shared types, constants and helpers of the scanline pixel unpacker.
// ----------------------------------------------------------------------------
package tspu_pkg;

    localparam int MAX_COLS_DEF      = 4096;
    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int OUT_MAX_DEF       = 65535;

    localparam int S_TDATA_W  = 72;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int COLS_REG_W = 13;

    typedef enum logic [1:0] {
        OP_DATA = 2'd0,
        OP_ROW  = 2'd1,
        OP_PAL  = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_BLACK = 2'd0,
        MODE_WHITE = 2'd1,
        MODE_PAL   = 2'd2,
        MODE_RGB   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STORE_RAW    = 2'd0,
        STORE_HIGH   = 2'd1,
        STORE_SCALED = 2'd2
    } t_store;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BPS        = 3'd0,
        CFG_MODE       = 3'd1,
        CFG_USE_PAL    = 3'd2,
        CFG_HAS_ALPHA  = 3'd3,
        CFG_PLANAR     = 3'd4,
        CFG_ROW_COLS   = 3'd5,
        CFG_STORE_MODE = 3'd6
    } t_cfg_idx;

    // pixel source resolved in the second stage
    typedef enum logic [1:0] {
        SRC_DIRECT = 2'd0,
        SRC_PAL    = 2'd1,
        SRC_LINE   = 2'd2
    } t_src;

    typedef struct packed {
        logic [3:0]            bps;
        t_mode                 mode;
        logic                  use_pal;
        logic                  has_alpha;
        logic                  planar;
        logic [COLS_REG_W-1:0] row_cols;
        t_store                store_mode;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        bps:        4'd8,
        mode:       MODE_BLACK,
        use_pal:    1'b1,
        has_alpha:  1'b0,
        planar:     1'b0,
        row_cols:   13'd4096,
        store_mode: STORE_RAW
    };

    typedef struct packed {
        t_src        src;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] column;
        logic        row_end;
        logic        last;
    } t_emit;

    // sample width as a log2 code; unsupported widths act as 8
    function automatic logic [1:0] bps_log(input logic [3:0] bps);
        logic [1:0] l;
        unique case (bps)
            4'd1:    l = 2'd0;
            4'd2:    l = 2'd1;
            4'd4:    l = 2'd2;
            default: l = 2'd3;
        endcase
        return l;
    endfunction

    function automatic logic [3:0] samples_per_byte(input logic [1:0] l);
        logic [3:0] n;
        unique case (l)
            2'd0:    n = 4'd8;
            2'd1:    n = 4'd4;
            2'd2:    n = 4'd2;
            default: n = 4'd1;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] sample_max(input logic [1:0] l);
        logic [7:0] m;
        unique case (l)
            2'd0:    m = 8'h01;
            2'd1:    m = 8'h03;
            2'd2:    m = 8'h0F;
            default: m = 8'hFF;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] sample_top(input logic [7:0] sh, input logic [1:0] l);
        logic [7:0] s;
        unique case (l)
            2'd0:    s = {7'b0, sh[7]};
            2'd1:    s = {6'b0, sh[7:6]};
            2'd2:    s = {4'b0, sh[7:4]};
            default: s = sh;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] sample_shift(input logic [7:0] sh, input logic [1:0] l);
        logic [7:0] r;
        unique case (l)
            2'd0:    r = {sh[6:0], 1'b0};
            2'd1:    r = {sh[5:0], 2'b0};
            2'd2:    r = {sh[3:0], 4'b0};
            default: r = 8'b0;
        endcase
        return r;
    endfunction

    // floor(p / 65535) for p < 65535*65536: p = a*65536 + b = a*65535 + (a + b)
    function automatic logic [15:0] div_65535(input logic [31:0] p);
        localparam logic [16:0] ONE_DIV = 17'd65535;
        localparam logic [16:0] TWO_DIV = 17'd131070;
        logic [16:0] t;
        logic [16:0] q;
        t = {1'b0, p[31:16]} + {1'b0, p[15:0]};
        if (t >= TWO_DIV) begin
            q = {1'b0, p[31:16]} + 17'd2;
        end else if (t >= ONE_DIV) begin
            q = {1'b0, p[31:16]} + 17'd1;
        end else begin
            q = {1'b0, p[31:16]};
        end
        return q[15:0];
    endfunction

    function automatic logic [15:0] store_value(input t_store m, input logic [15:0] v,
                                                input logic [31:0] p);
        logic [15:0] r;
        unique case (m)
            STORE_HIGH:   r = {8'b0, v[15:8]};
            STORE_SCALED: r = div_65535(p);
            default:      r = v;
        endcase
        return r;
    endfunction

endpackage

### rtl/tiff_scanline_pixel_unpacker_unit.sv
// ----------------------------------------------------------------------------
// tiff_scanline_pixel_unpacker_unit
// Unpacks MSB-first 1/2/4/8-bit TIFF scanline samples into one RGB pixel per
// column: min-is-black, min-is-white, colour map, chunky or planar RGB.
//
//  channel    direction  beat
//  s_axis     in         one scanline byte, row start or colour map write
//  m_axis     out        one pixel
//  cfg        in         one register write, no read-back
//
// A data byte holds the stepper until its samples are used or the row is full;
// row starts, map writes, 8-bit and planar bytes are taken whole. A pixel is
// registered in the pixel stage and at the output; items follow without a gap.
// Reset clears control state only; map and line stores are not cleared.
// A stall on m_axis backs up through the pixel stage into s_axis tready.
// ----------------------------------------------------------------------------
module tiff_scanline_pixel_unpacker_unit #(
    parameter int MAX_COLS      = tspu_pkg::MAX_COLS_DEF,
    parameter int PALETTE_DEPTH = tspu_pkg::PALETTE_DEPTH_DEF,
    parameter int OUT_MAX       = tspu_pkg::OUT_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // data_byte[7:0], plane_index[9:8], palette_index[17:10], pal_red[33:18],
    // pal_green[49:34], pal_blue[65:50], zero[71:66]
    input  logic [tspu_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // opcode[1:0]
    input  logic [tspu_pkg::S_TUSER_W-1:0]  i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // red[15:0], green[31:16], blue[47:32], column[59:48], zero[63:60]
    output logic [tspu_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    // row_end
    output logic                            o_m_axis_tlast,
    // last[0]
    output logic [0:0]                      o_m_axis_tuser,
    input  logic                            i_cfg_we,
    input  logic [tspu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tspu_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int PAW = $clog2(PALETTE_DEPTH);

    tspu_pkg::t_cfg  r_cfg, n_cfg;
    tspu_pkg::t_emit emit;
    logic            emit_valid, emit_ready;
    logic            pal_we, pal_re, red_we, grn_we, line_re;
    logic [PAW-1:0]  pal_waddr, pal_raddr;
    logic [47:0]     pal_wdata, pal_rdata;
    logic [LAW-1:0]  line_addr;
    logic [7:0]      line_wdata, red_rdata, grn_rdata;
    logic            out_last;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (tspu_pkg::t_cfg_idx'(i_cfg_idx))
                tspu_pkg::CFG_BPS:        n_cfg.bps        = i_cfg_data[3:0];
                tspu_pkg::CFG_MODE:       n_cfg.mode       = tspu_pkg::t_mode'(i_cfg_data[1:0]);
                tspu_pkg::CFG_USE_PAL:    n_cfg.use_pal    = i_cfg_data[0];
                tspu_pkg::CFG_HAS_ALPHA:  n_cfg.has_alpha  = i_cfg_data[0];
                tspu_pkg::CFG_PLANAR:     n_cfg.planar     = i_cfg_data[0];
                tspu_pkg::CFG_ROW_COLS:   n_cfg.row_cols   = i_cfg_data;
                tspu_pkg::CFG_STORE_MODE: n_cfg.store_mode = tspu_pkg::t_store'(i_cfg_data[1:0]);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= tspu_pkg::CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    tspu_stepper #(
        .MAX_COLS      (MAX_COLS),
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .OUT_MAX       (OUT_MAX)
    ) u_stepper (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_op         (tspu_pkg::t_op'(i_s_axis_tuser[1:0])),
        .i_byte       (i_s_axis_tdata[7:0]),
        .i_plane      (i_s_axis_tdata[9:8]),
        .i_pal_idx    (i_s_axis_tdata[17:10]),
        .i_pal_red    (i_s_axis_tdata[33:18]),
        .i_pal_green  (i_s_axis_tdata[49:34]),
        .i_pal_blue   (i_s_axis_tdata[65:50]),
        .i_emit_ready (emit_ready),
        .o_emit_valid (emit_valid),
        .o_emit       (emit),
        .o_pal_we     (pal_we),
        .o_pal_waddr  (pal_waddr),
        .o_pal_wdata  (pal_wdata),
        .o_pal_re     (pal_re),
        .o_pal_raddr  (pal_raddr),
        .o_red_we     (red_we),
        .o_grn_we     (grn_we),
        .o_line_re    (line_re),
        .o_line_addr  (line_addr),
        .o_line_wdata (line_wdata)
    );

    tspu_store #(
        .MAX_COLS      (MAX_COLS),
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_store (
        .i_clk        (i_clk),
        .i_pal_we     (pal_we),
        .i_pal_waddr  (pal_waddr),
        .i_pal_wdata  (pal_wdata),
        .i_pal_re     (pal_re),
        .i_pal_raddr  (pal_raddr),
        .o_pal_rdata  (pal_rdata),
        .i_red_we     (red_we),
        .i_grn_we     (grn_we),
        .i_line_re    (line_re),
        .i_line_addr  (line_addr),
        .i_line_wdata (line_wdata),
        .o_red_rdata  (red_rdata),
        .o_grn_rdata  (grn_rdata)
    );

    tspu_pixel u_pixel (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_emit_valid (emit_valid),
        .o_emit_ready (emit_ready),
        .i_emit       (emit),
        .i_pal_rdata  (pal_rdata),
        .i_red_rdata  (red_rdata),
        .i_grn_rdata  (grn_rdata),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_data       (o_m_axis_tdata),
        .o_row_end    (o_m_axis_tlast),
        .o_last       (out_last)
    );

    assign o_m_axis_tuser = out_last;

endmodule

### rtl/tspu_store.sv
// ----------------------------------------------------------------------------
// tspu_store
// Colour map and the red/green line stores; synchronous, registered reads.
// ----------------------------------------------------------------------------
module tspu_store #(
    parameter int MAX_COLS      = tspu_pkg::MAX_COLS_DEF,
    parameter int PALETTE_DEPTH = tspu_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_pal_we,
    input  logic [$clog2(PALETTE_DEPTH)-1:0]            i_pal_waddr,
    input  logic [47:0]                                 i_pal_wdata,
    input  logic                                        i_pal_re,
    input  logic [$clog2(PALETTE_DEPTH)-1:0]            i_pal_raddr,
    output logic [47:0]                                 o_pal_rdata,
    input  logic                                        i_red_we,
    input  logic                                        i_grn_we,
    input  logic                                        i_line_re,
    input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] i_line_addr,
    input  logic [7:0]                                  i_line_wdata,
    output logic [7:0]                                  o_red_rdata,
    output logic [7:0]                                  o_grn_rdata
);

    logic [47:0] r_pal   [PALETTE_DEPTH];
    logic [7:0]  r_red_l [MAX_COLS];
    logic [7:0]  r_grn_l [MAX_COLS];

    always_ff @(posedge i_clk) begin
        if (i_pal_we) begin
            r_pal[i_pal_waddr] <= i_pal_wdata;
        end
        if (i_pal_re) begin
            o_pal_rdata <= r_pal[i_pal_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_red_we) begin
            r_red_l[i_line_addr] <= i_line_wdata;
        end
        if (i_line_re) begin
            o_red_rdata <= r_red_l[i_line_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_grn_we) begin
            r_grn_l[i_line_addr] <= i_line_wdata;
        end
        if (i_line_re) begin
            o_grn_rdata <= r_grn_l[i_line_addr];
        end
    end

endmodule

### rtl/tspu_stepper.sv
// ----------------------------------------------------------------------------
// tspu_stepper
// Holds one input item and takes one sample of it per cycle unless stalled;
// keeps row position, chunky channel phase and held colours; drives the stores.
// ----------------------------------------------------------------------------
module tspu_stepper #(
    parameter int MAX_COLS      = tspu_pkg::MAX_COLS_DEF,
    parameter int PALETTE_DEPTH = tspu_pkg::PALETTE_DEPTH_DEF,
    parameter int OUT_MAX       = tspu_pkg::OUT_MAX_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  tspu_pkg::t_cfg                              i_cfg,
    input  logic                                        i_valid,
    output logic                                        o_ready,
    input  tspu_pkg::t_op                               i_op,
    input  logic [7:0]                                  i_byte,
    input  logic [1:0]                                  i_plane,
    input  logic [7:0]                                  i_pal_idx,
    input  logic [15:0]                                 i_pal_red,
    input  logic [15:0]                                 i_pal_green,
    input  logic [15:0]                                 i_pal_blue,
    input  logic                                        i_emit_ready,
    output logic                                        o_emit_valid,
    output tspu_pkg::t_emit                             o_emit,
    output logic                                        o_pal_we,
    output logic [$clog2(PALETTE_DEPTH)-1:0]            o_pal_waddr,
    output logic [47:0]                                 o_pal_wdata,
    output logic                                        o_pal_re,
    output logic [$clog2(PALETTE_DEPTH)-1:0]            o_pal_raddr,
    output logic                                        o_red_we,
    output logic                                        o_grn_we,
    output logic                                        o_line_re,
    output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] o_line_addr,
    output logic [7:0]                                  o_line_wdata
);

    localparam int CW   = $clog2(MAX_COLS + 1);
    localparam int CMPW = (CW > tspu_pkg::COLS_REG_W) ? CW : tspu_pkg::COLS_REG_W;
    localparam int LAW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int PAW  = $clog2(PALETTE_DEPTH);
    localparam int PIW  = (PAW > 8) ? PAW : 8;

    // control
    logic          r_busy, n_busy;
    logic [CW-1:0] r_cc, n_cc;
    logic [1:0]    r_phase, n_phase;
    logic [7:0]    r_held_r, n_held_r;
    logic [7:0]    r_held_g, n_held_g;
    logic [1:0]    r_cur_plane, n_cur_plane;

    // item payload
    tspu_pkg::t_op r_op, n_op;
    logic [7:0]    r_sh, n_sh;
    logic [3:0]    r_rem, n_rem;
    logic [1:0]    r_plane, n_plane;
    logic [7:0]    r_pal_idx, n_pal_idx;
    logic [15:0]   r_pal_vr, r_pal_vg, r_pal_vb;
    logic [31:0]   r_pal_pr, r_pal_pg, r_pal_pb;

    logic            accept, step_en, step_done, emit;
    tspu_pkg::t_emit emit_d;
    logic [1:0]      lg;
    logic [7:0]      smp, maxv;
    logic [CMPW-1:0] ccx, wx, ccx_p1;
    logic            full, row_end, last_smp, planar, pal_hit, pidx_ok;
    logic [3:0]      rem_after, need;
    logic [PIW-1:0]  smp_ext, pidx_ext;

    assign lg       = tspu_pkg::bps_log(i_cfg.bps);
    assign smp      = tspu_pkg::sample_top(r_sh, lg);
    assign maxv     = tspu_pkg::sample_max(lg);
    assign ccx      = CMPW'(r_cc);
    assign ccx_p1   = ccx + CMPW'(1);
    assign wx       = (CMPW'(i_cfg.row_cols) > CMPW'(MAX_COLS)) ? CMPW'(MAX_COLS)
                                                                 : CMPW'(i_cfg.row_cols);
    assign full     = (ccx >= wx);
    assign row_end  = (ccx_p1 == wx);
    assign last_smp = (r_rem == 4'd1);
    assign planar   = (i_cfg.mode == tspu_pkg::MODE_RGB) && i_cfg.planar;
    assign rem_after = r_rem - 4'd1;
    assign need      = i_cfg.has_alpha ? 4'd4 : 4'd3;
    assign smp_ext   = PIW'(smp);
    assign pidx_ext  = PIW'(r_pal_idx);
    assign pal_hit   = ({24'b0, smp} < 32'(PALETTE_DEPTH));
    assign pidx_ok   = ({24'b0, r_pal_idx} < 32'(PALETTE_DEPTH));

    assign step_en = r_busy && i_emit_ready;
    assign o_ready = !r_busy || (step_en && step_done);
    assign accept  = i_valid && o_ready;

    assign o_emit_valid = emit;
    assign o_emit       = emit_d;
    assign o_pal_waddr  = pidx_ext[PAW-1:0];
    assign o_pal_wdata  = {tspu_pkg::store_value(i_cfg.store_mode, r_pal_vb, r_pal_pb),
                           tspu_pkg::store_value(i_cfg.store_mode, r_pal_vg, r_pal_pg),
                           tspu_pkg::store_value(i_cfg.store_mode, r_pal_vr, r_pal_pr)};
    assign o_pal_raddr  = smp_ext[PAW-1:0];
    assign o_pal_re     = emit && (emit_d.src == tspu_pkg::SRC_PAL);
    assign o_line_re    = emit && (emit_d.src == tspu_pkg::SRC_LINE);
    assign o_line_addr  = r_cc[LAW-1:0];
    assign o_line_wdata = r_sh;

    always_comb begin
        n_busy      = r_busy;
        n_cc        = r_cc;
        n_phase     = r_phase;
        n_held_r    = r_held_r;
        n_held_g    = r_held_g;
        n_cur_plane = r_cur_plane;
        n_op        = r_op;
        n_sh        = r_sh;
        n_rem       = r_rem;
        n_plane     = r_plane;
        n_pal_idx   = r_pal_idx;
        step_done   = 1'b0;
        emit        = 1'b0;
        o_pal_we    = 1'b0;
        o_red_we    = 1'b0;
        o_grn_we    = 1'b0;
        emit_d.src     = tspu_pkg::SRC_DIRECT;
        emit_d.red     = 8'd0;
        emit_d.green   = 8'd0;
        emit_d.blue    = 8'd0;
        emit_d.column  = ccx[11:0];
        emit_d.row_end = row_end;
        emit_d.last    = last_smp || row_end;

        if (step_en) begin
            unique case (r_op)
                tspu_pkg::OP_ROW: begin
                    n_cc        = '0;
                    n_phase     = 2'd0;
                    n_cur_plane = r_plane;
                    step_done   = 1'b1;
                end
                tspu_pkg::OP_PAL: begin
                    o_pal_we  = pidx_ok;
                    step_done = 1'b1;
                end
                tspu_pkg::OP_DATA: begin
                    if (full) begin
                        step_done = 1'b1;
                    end else if (planar) begin
                        step_done = 1'b1;
                        unique case (r_cur_plane)
                            2'd0: begin
                                o_red_we = 1'b1;
                                n_cc     = r_cc + CW'(1);
                            end
                            2'd1: begin
                                o_grn_we = 1'b1;
                                n_cc     = r_cc + CW'(1);
                            end
                            2'd2: begin
                                emit        = 1'b1;
                                emit_d.src  = tspu_pkg::SRC_LINE;
                                emit_d.blue = r_sh;
                                emit_d.last = 1'b1;
                                n_cc        = r_cc + CW'(1);
                            end
                            default: begin
                            end
                        endcase
                    end else begin
                        n_sh      = tspu_pkg::sample_shift(r_sh, lg);
                        n_rem     = rem_after;
                        step_done = last_smp;
                        unique case (i_cfg.mode)
                            tspu_pkg::MODE_BLACK: begin
                                emit        = 1'b1;
                                emit_d.blue = smp;
                            end
                            tspu_pkg::MODE_WHITE: begin
                                emit        = 1'b1;
                                emit_d.blue = maxv - smp;
                            end
                            tspu_pkg::MODE_PAL: begin
                                emit = 1'b1;
                                if (!i_cfg.use_pal) begin
                                    emit_d.blue = smp;
                                end else if (pal_hit) begin
                                    emit_d.src = tspu_pkg::SRC_PAL;
                                end
                            end
                            default: begin
                                unique case (r_phase)
                                    2'd0: begin
                                        n_held_r = smp;
                                        n_phase  = 2'd1;
                                    end
                                    2'd1: begin
                                        n_held_g = smp;
                                        n_phase  = 2'd2;
                                    end
                                    2'd2: begin
                                        emit         = 1'b1;
                                        emit_d.red   = r_held_r;
                                        emit_d.green = r_held_g;
                                        emit_d.blue  = smp;
                                        emit_d.last  = last_smp || row_end || (rem_after < need);
                                        n_phase      = i_cfg.has_alpha ? 2'd3 : 2'd0;
                                    end
                                    default: begin
                                        n_phase = 2'd0;
                                    end
                                endcase
                            end
                        endcase
                        if (emit) begin
                            n_cc = r_cc + CW'(1);
                            if (row_end) begin
                                step_done = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    step_done = 1'b1;
                end
            endcase
        end

        if (accept) begin
            n_busy    = 1'b1;
            n_op      = i_op;
            n_sh      = i_byte;
            n_rem     = tspu_pkg::samples_per_byte(lg);
            n_plane   = i_plane;
            n_pal_idx = i_pal_idx;
        end else if (step_en && step_done) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cc        <= '0;
            r_phase     <= 2'd0;
            r_held_r    <= 8'd0;
            r_held_g    <= 8'd0;
            r_cur_plane <= 2'd0;
        end else begin
            r_busy      <= n_busy;
            r_cc        <= n_cc;
            r_phase     <= n_phase;
            r_held_r    <= n_held_r;
            r_held_g    <= n_held_g;
            r_cur_plane <= n_cur_plane;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_sh      <= n_sh;
        r_rem     <= n_rem;
        r_plane   <= n_plane;
        r_pal_idx <= n_pal_idx;
        if (accept) begin
            r_pal_vr <= i_pal_red;
            r_pal_vg <= i_pal_green;
            r_pal_vb <= i_pal_blue;
            r_pal_pr <= {16'b0, i_pal_red}   * 32'(OUT_MAX);
            r_pal_pg <= {16'b0, i_pal_green} * 32'(OUT_MAX);
            r_pal_pb <= {16'b0, i_pal_blue}  * 32'(OUT_MAX);
        end
    end

endmodule

### rtl/tspu_pixel.sv
// ----------------------------------------------------------------------------
// tspu_pixel
// Pixel stage: merges store read data into the pixel, then the output
// register towards the master side.
// ----------------------------------------------------------------------------
module tspu_pixel (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_emit_valid,
    output logic                           o_emit_ready,
    input  tspu_pkg::t_emit                i_emit,
    input  logic [47:0]                    i_pal_rdata,
    input  logic [7:0]                     i_red_rdata,
    input  logic [7:0]                     i_grn_rdata,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [tspu_pkg::M_TDATA_W-1:0] o_data,
    output logic                           o_row_end,
    output logic                           o_last
);

    logic            r_s2v, n_s2v;
    tspu_pkg::t_emit r_s2;
    logic            r_ov, n_ov;
    logic [tspu_pkg::M_TDATA_W-1:0] r_odata;
    logic            r_orow_end, r_olast;
    logic            out_free, s2_move;
    logic [15:0]     pix_r, pix_g, pix_b;

    assign out_free     = !r_ov || i_ready;
    assign s2_move      = r_s2v && out_free;
    assign o_emit_ready = !r_s2v || out_free;

    always_comb begin
        unique case (r_s2.src)
            tspu_pkg::SRC_PAL: begin
                pix_r = i_pal_rdata[15:0];
                pix_g = i_pal_rdata[31:16];
                pix_b = i_pal_rdata[47:32];
            end
            tspu_pkg::SRC_LINE: begin
                pix_r = {8'b0, i_red_rdata};
                pix_g = {8'b0, i_grn_rdata};
                pix_b = {8'b0, r_s2.blue};
            end
            default: begin
                pix_r = {8'b0, r_s2.red};
                pix_g = {8'b0, r_s2.green};
                pix_b = {8'b0, r_s2.blue};
            end
        endcase
    end

    always_comb begin
        n_s2v = r_s2v;
        if (i_emit_valid) begin
            n_s2v = 1'b1;
        end else if (s2_move) begin
            n_s2v = 1'b0;
        end
        n_ov = r_ov;
        if (s2_move) begin
            n_ov = 1'b1;
        end else if (i_ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2v <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            r_s2v <= n_s2v;
            r_ov  <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit_valid) begin
            r_s2 <= i_emit;
        end
        if (s2_move) begin
            r_odata    <= {4'b0, r_s2.column, pix_b, pix_g, pix_r};
            r_orow_end <= r_s2.row_end;
            r_olast    <= r_s2.last;
        end
    end

    assign o_valid   = r_ov;
    assign o_data    = r_odata;
    assign o_row_end = r_orow_end;
    assign o_last    = r_olast;

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the TIFF scanline pixel unpacker. Bytes, row starts
// and colour map writes go in on s_axis. An in-bench model predicts every
// pixel, and each m_axis beat is compared field by field with the oldest
// pixel still due. Short directed checks come first, then random phases that
// each set a new mode, sample width, row width and map store mode. Both
// sides idle at random; the receiver also holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
    import tspu_pkg::*;

    localparam int          SETTLE      = 16;
    localparam logic [1:0]  STORE_SPARE = 2'd3;

    typedef struct packed {
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        logic [11:0] col;
        logic        row_end;
        logic        last;
    } t_pixel;

    class pixel_book;
        logic [3:0]  bps;
        t_mode       mode;
        logic        use_pal;
        logic        has_alpha;
        logic        planar;
        logic [12:0] row_cols;
        logic [1:0]  store_mode;
        logic [15:0] map_r[256];
        logic [15:0] map_g[256];
        logic [15:0] map_b[256];
        bit          map_set[256];
        logic [7:0]  red_line[MAX_COLS_DEF];
        logic [7:0]  green_line[MAX_COLS_DEF];
        bit          red_set[MAX_COLS_DEF];
        bit          green_set[MAX_COLS_DEF];
        int          col_cnt;
        int          chan;
        int          cur_plane;
        logic [7:0]  held_r;
        logic [7:0]  held_g;
        t_pixel      pixels_due[$];
        t_pixel      batch[$];
        int          errors;
        int          pixels_seen;
        int          items_taken;

        function new();
            bps        = 4'd8;
            mode       = MODE_BLACK;
            use_pal    = 1'b1;
            has_alpha  = 1'b0;
            planar     = 1'b0;
            row_cols   = 13'd4096;
            store_mode = STORE_RAW;
            col_cnt    = 0;
            chan       = 0;
            cur_plane  = 0;
            held_r     = 8'h00;
            held_g     = 8'h00;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [12:0] v);
            case (idx)
                CFG_BPS:        bps        = v[3:0];
                CFG_MODE:       mode       = t_mode'(v[1:0]);
                CFG_USE_PAL:    use_pal    = v[0];
                CFG_HAS_ALPHA:  has_alpha  = v[0];
                CFG_PLANAR:     planar     = v[0];
                CFG_ROW_COLS:   row_cols   = v;
                CFG_STORE_MODE: store_mode = v[1:0];
                default: ;
            endcase
        endfunction

        function int row_width();
            return (row_cols > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(row_cols);
        endfunction

        function int sample_width();
            return (bps == 4'd1 || bps == 4'd2 || bps == 4'd4) ? int'(bps) : 8;
        endfunction

        function logic [15:0] kept(logic [15:0] v);
            longint unsigned p;
            p = v;
            p = p * OUT_MAX_DEF;
            if (store_mode == STORE_HIGH) return {8'h00, v[15:8]};
            if (store_mode == STORE_SCALED) return 16'(p / 65535);
            return v;
        endfunction

        function void put_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
            int w;
            w = row_width();
            if (col_cnt >= w) return;
            batch.push_back('{r, g, b, 12'(col_cnt), (col_cnt + 1 == w), 1'b0});
            col_cnt++;
        endfunction

        // true where the item would read a map or line entry never written
        function bit reads_unset(t_op op, logic [71:0] d);
            int         sw;
            int         left;
            logic [7:0] maxv;
            if (op != OP_DATA || col_cnt >= row_width()) return 1'b0;
            if (mode == MODE_RGB && planar)
                return cur_plane == 2 && !(red_set[col_cnt] && green_set[col_cnt]);
            if (mode == MODE_PAL && use_pal) begin
                sw   = sample_width();
                maxv = 8'((1 << sw) - 1);
                for (left = 8 - sw; left >= 0; left -= sw)
                    if (!map_set[(d[7:0] >> left) & maxv]) return 1'b1;
            end
            return 1'b0;
        endfunction

        function void take_item(t_op op, logic [71:0] d);
            int         sw;
            int         left;
            int         w;
            int         c;
            logic [7:0] dbyte;
            logic [7:0] pidx;
            logic [7:0] maxv;
            logic [7:0] s;
            dbyte = d[7:0];
            pidx  = d[17:10];
            w     = row_width();
            batch.delete();
            items_taken++;
            if (op == OP_ROW) begin
                col_cnt   = 0;
                chan      = 0;
                cur_plane = int'(d[9:8]);
            end else if (op == OP_PAL) begin
                map_r[pidx]   = kept(d[33:18]);
                map_g[pidx]   = kept(d[49:34]);
                map_b[pidx]   = kept(d[65:50]);
                map_set[pidx] = 1'b1;
            end else if (op == OP_DATA && col_cnt < w) begin
                if (mode == MODE_RGB && planar) begin
                    c = col_cnt;
                    case (cur_plane)
                        0: begin
                            red_line[c] = dbyte;
                            red_set[c]  = 1'b1;
                            col_cnt++;
                        end
                        1: begin
                            green_line[c] = dbyte;
                            green_set[c]  = 1'b1;
                            col_cnt++;
                        end
                        2: put_pixel({8'h00, red_line[c]}, {8'h00, green_line[c]},
                                     {8'h00, dbyte});
                        default: ;
                    endcase
                end else begin
                    sw   = sample_width();
                    maxv = 8'((1 << sw) - 1);
                    left = 8;
                    while (left > 0) begin
                        left -= sw;
                        s = (dbyte >> left) & maxv;
                        if (col_cnt >= w) break;
                        case (mode)
                            MODE_BLACK: put_pixel(16'h0, 16'h0, {8'h00, s});
                            MODE_WHITE: put_pixel(16'h0, 16'h0, {8'h00, maxv - s});
                            MODE_PAL: begin
                                if (!use_pal) put_pixel(16'h0, 16'h0, {8'h00, s});
                                else put_pixel(map_r[s], map_g[s], map_b[s]);
                            end
                            default: begin
                                if (chan == 0) begin
                                    held_r = s;
                                    chan   = 1;
                                end else if (chan == 1) begin
                                    held_g = s;
                                    chan   = 2;
                                end else if (chan == 2) begin
                                    put_pixel({8'h00, held_r}, {8'h00, held_g}, {8'h00, s});
                                    chan = has_alpha ? 3 : 0;
                                end else begin
                                    chan = 0;
                                end
                            end
                        endcase
                    end
                end
            end
            if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i]) pixels_due.push_back(batch[i]);
        endfunction

        task flag_mismatch(string what, longint unsigned got, longint unsigned want);
            $display("mismatch at pixel %0d: %s got 0x%0h want 0x%0h",
                     pixels_seen, what, got, want);
            errors++;
        endtask

        task match_pixel(logic [63:0] td, logic row_end, logic last);
            t_pixel due;
            pixels_seen++;
            if (pixels_due.size() == 0) begin
                flag_mismatch("pixel with nothing due", td, 0);
                return;
            end
            due = pixels_due.pop_front();
            if (td[15:0] != due.r) flag_mismatch("red", td[15:0], due.r);
            if (td[31:16] != due.g) flag_mismatch("green", td[31:16], due.g);
            if (td[47:32] != due.b) flag_mismatch("blue", td[47:32], due.b);
            if (td[59:48] != due.col) flag_mismatch("column", td[59:48], due.col);
            if (row_end != due.row_end) flag_mismatch("row_end", row_end, due.row_end);
            if (last != due.last) flag_mismatch("last", last, due.last);
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [S_TDATA_W-1:0]  s_data = '0;
    logic [S_TUSER_W-1:0]  s_op = OP_NONE;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [M_TDATA_W-1:0]  m_data;
    logic                  m_last;
    logic [0:0]            m_user;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = CFG_BPS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bit        src_quiet = 1'b0;
    bit        rcv_quiet = 1'b0;
    int        hold_len  = 0;
    pixel_book book = new();

    tiff_scanline_pixel_unpacker_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_op),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .o_m_axis_tuser  (m_user),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic int pause(bit quiet);
        if (quiet || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 18);
    endfunction

    function automatic logic [71:0] pack_item(logic [7:0] dbyte, logic [1:0] plane,
                                              logic [7:0] pidx, logic [15:0] pr,
                                              logic [15:0] pg, logic [15:0] pb);
        return {6'b0, pb, pg, pr, pidx, plane, dbyte};
    endfunction

    task automatic send(t_op op, logic [71:0] d);
        int gap;
        gap = pause(src_quiet);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid = 1'b1;
        s_op    = op;
        s_data  = d;
        do @(posedge clk); while (!s_ready);
        book.take_item(op, d);
        @(negedge clk);
    endtask

    task automatic send_byte(logic [7:0] v);
        send(OP_DATA, pack_item(v, 2'd0, 8'd0, 16'd0, 16'd0, 16'd0));
    endtask

    task automatic send_row(logic [1:0] plane);
        send(OP_ROW, pack_item(8'd0, plane, 8'd0, 16'd0, 16'd0, 16'd0));
    endtask

    task automatic cfg(t_cfg_idx idx, int v);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = CFG_DATA_W'(v);
        book.set_reg(idx, CFG_DATA_W'(v));
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // wait out every pixel due, then let a stepper still busy past the row end finish
    task automatic settle();
        s_valid = 1'b0;
        while (book.pixels_due.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic random_phase(int ph);
        int          bps_tab[4];
        int          odd_tab[4];
        int          n;
        int          r;
        int          wid;
        int          target;
        int          in_row;
        int          plane;
        t_mode       md;
        bit          pl;
        bit          up;
        t_op         op;
        logic [71:0] d;
        bps_tab = '{1, 2, 4, 8};
        odd_tab = '{0, 3, 5, 15};
        md      = t_mode'(ph % 4);
        pl      = (ph == 7);
        up      = (ph != 6);
        wid     = (ph == 0) ? 8191 : (ph == 3) ? 1 : pl ? $urandom_range(1, 12)
                                                     : $urandom_range(2, 24);
        settle();
        cfg(CFG_BPS, (ph == 1) ? odd_tab[$urandom_range(0, 3)] :
                     (ph == 4) ? 1 : bps_tab[$urandom_range(0, 3)]);
        cfg(CFG_MODE, md);
        cfg(CFG_USE_PAL, up);
        cfg(CFG_HAS_ALPHA, (ph == 3) ? 0 : $urandom_range(0, 1));
        cfg(CFG_PLANAR, pl);
        cfg(CFG_ROW_COLS, wid);
        cfg(CFG_STORE_MODE, ph % 4);
        src_quiet = (ph % 3 == 1) || (ph == 4);
        rcv_quiet = (ph % 3 == 1);

        if (md == MODE_PAL && up)
            for (n = 0; n < 16; n++)
                send(OP_PAL, pack_item(8'($urandom), 2'($urandom), 8'(n), 16'($urandom),
                                       16'($urandom), 16'($urandom)));

        plane  = 0;
        in_row = 0;
        target = pl ? wid + $urandom_range(0, 2) : $urandom_range(1, 12);
        send_row(2'd0);
        for (n = 0; n < 38; n++) begin
            if (ph == 4 && n == 8) hold_len = 400;
            if (ph == 4 && n == 30) begin
                s_valid = 1'b0;
                while (book.pixels_due.size() != 0) @(negedge clk);
            end
            r = $urandom_range(0, 99);
            d = pack_item(8'($urandom), 2'($urandom), 8'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom));
            if (r < 5) begin
                op = OP_NONE;
            end else if (r < 11) begin
                op = OP_PAL;
            end else if (r < 15) begin
                op = OP_ROW;
            end else if (in_row >= target) begin
                op      = OP_ROW;
                plane   = pl ? (plane + 1) % 3 : 0;
                d[9:8]  = 2'(plane);
                in_row  = 0;
                target  = pl ? wid + $urandom_range(0, 2) : $urandom_range(1, 12);
            end else begin
                op = OP_DATA;
                in_row++;
            end
            if (book.reads_unset(op, d)) begin
                if (pl) begin
                    op     = OP_ROW;
                    d[9:8] = 2'd0;
                    plane  = 0;
                    in_row = 0;
                end else begin
                    d[7:0] = 8'($urandom_range(0, 15));
                end
            end
            send(op, d);
        end
    endtask

    // receiver: random stalls per beat, plus one long hold-off on request
    initial begin
        int gap;
        @(posedge rst_n);
        forever begin
            gap = pause(rcv_quiet);
            if (gap > 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            if (hold_len > 0) begin
                m_ready = 1'b0;
                repeat (hold_len) @(negedge clk);
                hold_len = 0;
            end
            m_ready = 1'b1;
            do @(posedge clk); while (!m_valid);
            book.match_pixel(m_data, m_last, m_user[0]);
            @(negedge clk);
        end
    end

    initial begin
        #3200000;
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        int ph;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // reset settings: 8-bit min-is-black, full width, raw map writes
        send_byte(8'h00);
        send_byte(8'hFF);
        send(OP_NONE, pack_item(8'hFF, 2'd3, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_row(2'd3);
        send_byte(8'hA5);
        send_row(2'd0);
        send(OP_PAL, pack_item(8'h00, 2'd0, 8'd0, 16'h0000, 16'hFFFF, 16'h1234));
        send(OP_PAL, pack_item(8'h00, 2'd0, 8'd255, 16'hFFFF, 16'h0000, 16'hABCD));

        // 1-bit colour map, three columns, then bytes past the row end
        settle();
        cfg(CFG_BPS, 1);
        cfg(CFG_MODE, MODE_PAL);
        cfg(CFG_ROW_COLS, 3);
        cfg(CFG_STORE_MODE, STORE_HIGH);
        send(OP_PAL, pack_item(8'h00, 2'd0, 8'd1, 16'hFFFF, 16'h00FF, 16'h8001));
        send_row(2'd0);
        send_byte(8'h80);
        send_byte(8'hFF);

        settle();
        cfg(CFG_ROW_COLS, 0);
        send_byte(8'h5A);

        // odd sample width, over-wide row
        settle();
        cfg(CFG_BPS, 3);
        cfg(CFG_MODE, MODE_WHITE);
        cfg(CFG_ROW_COLS, 8191);
        send_row(2'd0);
        send_byte(8'h00);
        send_byte(8'hFF);
        settle();
        cfg(CFG_MODE, MODE_PAL);
        send_byte(8'hFF);

        // chunky RGB with alpha skipped
        settle();
        cfg(CFG_MODE, MODE_RGB);
        cfg(CFG_HAS_ALPHA, 1);
        cfg(CFG_BPS, 4);
        cfg(CFG_ROW_COLS, 2);
        cfg(CFG_STORE_MODE, STORE_SCALED);
        send(OP_PAL, pack_item(8'h00, 2'd0, 8'd2, 16'hFFFF, 16'h8000, 16'h0001));
        send_row(2'd0);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h56);
        send_byte(8'h78);

        // planar RGB
        settle();
        cfg(CFG_PLANAR, 1);
        cfg(CFG_BPS, 8);
        cfg(CFG_STORE_MODE, STORE_SPARE);
        send_row(2'd0);
        send_byte(8'h11);
        send_byte(8'h22);
        send_row(2'd1);
        send_byte(8'h33);
        send_byte(8'h44);
        send_row(2'd2);
        send_byte(8'h55);
        send_byte(8'h66);

        for (ph = 0; ph < 8; ph++) random_phase(ph);

        settle();
        $display("tb_top: %0d items taken, %0d pixels checked", book.items_taken,
                 book.pixels_seen);
        $display("tb_top: all four modes, 1/2/4/8-bit and odd widths, rows 0 to 8191 wide");
        if (book.errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

### sim.f
rtl/tspu_pkg.sv
rtl/tspu_store.sv
rtl/tspu_stepper.sv
rtl/tspu_pixel.sv
rtl/tiff_scanline_pixel_unpacker_unit.sv
verif/tb_top.sv
